FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Types, constants and lead byte decoding shared by the validator modules.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int unsigned CountW = 32;

	localparam logic [7:0] ByteNul     = 8'h00;
	localparam logic [7:0] ByteNewline = 8'h0a;

	localparam logic STATUS_VALID   = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef logic [CountW-1:0] count_t;
	typedef logic [2:0]        pend_t;

	// Decoded lead byte: ok is low for a byte that cannot start a sequence.
	typedef struct packed {
		logic  ok;
		pend_t len;
	} lead_t;

	// Decision for the byte in the input register.
	typedef struct packed {
		logic   emit;
		logic   status;
		count_t line_count;
	} result_t;

	function automatic lead_t lead_decode(input logic [7:0] b);
		lead_t r;
		r.ok  = 1'b1;
		r.len = 3'd0;
		if ((b & 8'h80) == 8'h00) begin
			r.len = 3'd0;
		end else if ((b & 8'he0) == 8'hc0) begin
			r.len = 3'd1;
		end else if ((b & 8'hf0) == 8'he0) begin
			r.len = 3'd2;
		end else if ((b & 8'hf8) == 8'hf0) begin
			r.len = 3'd3;
		end else if ((b & 8'hfc) == 8'hf8) begin
			r.len = 3'd4;
		end else if ((b & 8'hfe) == 8'hfc) begin
			r.len = 3'd5;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic logic is_continuation(input logic [7:0] b);
		return (b & 8'hc0) == 8'h80;
	endfunction

endpackage

FILE: src/utf8v_in_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 validator input stage
// Holds one incoming byte until the checker consumes it.
// ----------------------------------------------------------------------------
module utf8v_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

FILE: src/utf8v_core.sv
// ----------------------------------------------------------------------------
// UTF-8 validator core
// Sequence state, discard flag, newline counter and per-byte decision.
// ----------------------------------------------------------------------------
module utf8v_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        byte_s1,
	input  logic              count_lines_q,
	output utf8v_pkg::result_t res
);

	utf8v_pkg::pend_t  pend_q, pend_d;
	logic              discard_q, discard_d;
	utf8v_pkg::count_t count_q, count_d;
	utf8v_pkg::lead_t  lead;

	assign lead = utf8v_pkg::lead_decode(byte_s1);

	always_comb begin
		pend_d     = pend_q;
		discard_d  = discard_q;
		count_d    = count_q;
		res.emit   = 1'b0;
		res.status = utf8v_pkg::STATUS_VALID;
		res.line_count = count_q;
		if (discard_q) begin
			if (byte_s1 == utf8v_pkg::ByteNul) begin
				discard_d = 1'b0;
			end
		end else if (pend_q != 3'd0) begin
			if (utf8v_pkg::is_continuation(byte_s1)) begin
				pend_d = pend_q - 3'd1;
			end else begin
				// A terminator ends the string here; any other byte starts a discard.
				pend_d     = 3'd0;
				discard_d  = byte_s1 != utf8v_pkg::ByteNul;
				res.emit   = 1'b1;
				res.status = utf8v_pkg::STATUS_INVALID;
			end
		end else if (byte_s1 == utf8v_pkg::ByteNul) begin
			res.emit = 1'b1;
		end else if (!lead.ok) begin
			discard_d  = 1'b1;
			res.emit   = 1'b1;
			res.status = utf8v_pkg::STATUS_INVALID;
		end else if (lead.len == 3'd0) begin
			if (byte_s1 == utf8v_pkg::ByteNewline && count_lines_q && !(&count_q)) begin
				count_d = count_q + utf8v_pkg::count_t'(1);
			end
		end else begin
			pend_d = lead.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 3'd0;
			discard_q <= 1'b0;
			count_q   <= '0;
		end else if (advance) begin
			pend_q    <= pend_d;
			discard_q <= discard_d;
			count_q   <= count_d;
		end
	end

endmodule

FILE: src/utf8v_out_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 validator output stage
// Result register that holds a verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module utf8v_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  utf8v_pkg::result_t res,
	output logic               room,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               status,
	output logic [31:0]        line_count
);

	assign room = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (room) begin
			result_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && room) begin
			status     <= res.status;
			line_count <= res.line_count;
		end
	end

endmodule

FILE: src/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Structural check of zero-terminated strings in six-byte UTF-8 form with
// a saturating newline counter.
// ----------------------------------------------------------------------------
//   Channel  Signals                               Direction
//   byte     byte_valid, byte_ready, data_byte     in
//   result   result_valid, result_ready,           out
//            status, line_count
//   config   cfg_write, cfg_data (count_lines)     in
//
// One byte per cycle unless intake stalls; a verdict moves from input to result register.
// The rate is set by the single pass through the decision logic and the
// 32-bit counter increment between input and result registers.
// Reset clears sequence state, counter and both stage valids; count_lines
// resets to one.
// A held result stalls intake only when the byte in the input register
// itself produces a result.
`include "assert_macros.svh"

module utf8_stream_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        status,
	output logic [31:0] line_count,
	input  logic        cfg_write,
	input  logic        cfg_data
);

	logic               count_lines_q;
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               advance;
	logic               room;
	utf8v_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_lines_q <= 1'b1;
		end else if (cfg_write) begin
			count_lines_q <= cfg_data;
		end
	end

	assign advance = valid_s1 && (!res.emit || room);

	utf8v_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	utf8v_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.byte_s1       (byte_s1),
		.count_lines_q (count_lines_q),
		.res           (res)
	);

	utf8v_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res.emit),
		.res          (res),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.line_count   (line_count)
	);

	// A verdict must never be consumed while the result register is blocked.
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, advance && res.emit && result_valid && !result_ready, "verdict advanced into a full result register")
	// A consumed verdict shows up in the result register on the next cycle.
	`ASSERT_CLK(a_emit_lands, clk, arst_n, advance && res.emit |=> result_valid, "verdict lost between stages")
	// The newline count only ever grows.
	`ASSERT_CLK(a_count_mono, clk, arst_n, $past(arst_n) |-> res.line_count >= $past(res.line_count), "newline counter went backwards")

endmodule
